// File: design/th565_pkg.sv
// Shared constants and types for the temperature heat-map pixel pipeline.
`default_nettype none
package th565_pkg;

   // Register indexes of the configuration port
   localparam logic CSR_MIN_TEMP = 1'b0;
   localparam logic CSR_MAX_TEMP = 1'b1;

   localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd1280;
   localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd2560;

   // Breakpoints as Q16 fractions of the span
   localparam logic [15:0] BRK_A_Q16 = 16'd13900;
   localparam logic [15:0] BRK_B_Q16 = 16'd20854;
   localparam logic [15:0] BRK_C_Q16 = 16'd27800;
   localparam logic [15:0] BRK_D_Q16 = 16'd53622;

   localparam logic [7:0] CAP_COLD = 8'd255;
   localparam logic [7:0] CAP_HOT  = 8'd240;

   localparam int POS_W = 35;   // signed scaled temperatures, relative to min_temp
   localparam int NUM_W = 34;   // positive ramp numerator
   localparam int DEN_W = 32;   // ramp denominator, span times a breakpoint gap
   localparam int REM_W = 42;   // numerator times gain
   localparam int QUO_W = 8;    // quotient bits

   typedef struct packed {
      logic              force_en;
      logic [7:0]        force_val;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic              hot;
   } ramp_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quo;
      logic [REM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic              hot;
   } div_type;

endpackage
`default_nettype wire

// File: design/temperature_to_rgb565_heatmap_core.sv
// Temperature sample to RGB565 false-color pixel, fully pipelined.
//
// Channels: req_valid/req_stall carry one signed temperature sample (degrees C
// times 64) per item; rsp_valid/rsp_stall return one pixel per item with its
// packed RGB565 word, the three eight-bit levels and a degenerate flag.
// The csr port writes min_temp (index 0) and max_temp (index 1); write it only
// while no item is in flight.
//
// One item is taken every cycle while the output is not stalled; the depth
// comes from the three 8-bit restoring dividers (one quotient bit per stage,
// one divider per color channel) plus the input, breakpoint multiply, ramp
// select, gain, saturation and output stages.
//
// Reset empties the pipeline and loads min_temp = 20.0 C, max_temp = 40.0 C.
// When the output holds an item and rsp_stall is high, the whole pipeline
// freezes and req_stall goes high; nothing is lost or repeated.
// When max_temp is not above min_temp the pixel is black and degenerate is set.
`default_nettype none
module temperature_to_rgb565_heatmap_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_temp_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [15:0]             rsp_color565,
   output logic [7:0]              rsp_red_level,
   output logic [7:0]              rsp_green_level,
   output logic [7:0]              rsp_blue_level,
   output logic                    rsp_degenerate,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_wdata
);

   localparam int NCH = 3;   // red, green, blue
   localparam int NDV = th565_pkg::QUO_W + 1;

   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // configuration
   logic signed [15:0] min_ff, max_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= th565_pkg::MIN_TEMP_RESET;
         max_ff <= th565_pkg::MAX_TEMP_RESET;
      end else if (csr_we) begin
         if (csr_index == th565_pkg::CSR_MIN_TEMP) min_ff <= $signed(csr_wdata);
         if (csr_index == th565_pkg::CSR_MAX_TEMP) max_ff <= $signed(csr_wdata);
      end
   end

   // stage 1: offsets from min_temp
   logic               s1_vld_ff, s1_deg_ff;
   logic signed [16:0] s1_diff_ff;
   logic [15:0]        s1_span_ff;
   logic signed [16:0] span_in;
   assign span_in = {max_ff[15], max_ff} - {min_ff[15], min_ff};

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_diff_ff <= {req_temp_value[15], req_temp_value} - {min_ff[15], min_ff};
         s1_span_ff <= span_in[15:0];
         s1_deg_ff  <= (max_ff <= min_ff);
      end
   end

   // stage 2: breakpoints, all relative to min_temp and scaled by 2^16
   logic                          s2_vld_ff, s2_deg_ff;
   logic signed [th565_pkg::POS_W-1:0] s2_v_ff;
   logic [31:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff, s2_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_deg_ff <= s1_deg_ff;
         s2_v_ff   <= {{2{s1_diff_ff[16]}}, s1_diff_ff, 16'd0};
         s2_a_ff   <= 32'(s1_span_ff) * 32'(th565_pkg::BRK_A_Q16);
         s2_b_ff   <= 32'(s1_span_ff) * 32'(th565_pkg::BRK_B_Q16);
         s2_c_ff   <= 32'(s1_span_ff) * 32'(th565_pkg::BRK_C_Q16);
         s2_d_ff   <= 32'(s1_span_ff) * 32'(th565_pkg::BRK_D_Q16);
         s2_hi_ff  <= {s1_span_ff, 16'd0};
      end
   end

   // stage 3: choose the ramp segment of each channel
   logic signed [th565_pkg::POS_W-1:0] pa, pb, pc, pd, ph, pv;
   logic signed [th565_pkg::POS_W-1:0] r_num, g_num, g_den, b_num, b_den;
   th565_pkg::ramp_type ramp_in [NCH];
   th565_pkg::ramp_type s3_ramp_ff [NCH];
   logic s3_vld_ff, s3_deg_ff;

   always_comb begin
      pv = s2_v_ff;
      pa = $signed({3'b000, s2_a_ff});
      pb = $signed({3'b000, s2_b_ff});
      pc = $signed({3'b000, s2_c_ff});
      pd = $signed({3'b000, s2_d_ff});
      ph = $signed({3'b000, s2_hi_ff});

      r_num = pv - pb;
      ramp_in[0].force_en  = (r_num <= 0);
      ramp_in[0].force_val = 8'd0;
      ramp_in[0].num       = r_num[th565_pkg::NUM_W-1:0];
      ramp_in[0].den       = s2_c_ff - s2_b_ff;
      ramp_in[0].hot       = 1'b0;

      g_num = pd - pv;
      g_den = pd - pc;
      ramp_in[1].force_en  = 1'b0;
      ramp_in[1].force_val = 8'd0;
      if (pv > 0 && pv < pa) begin
         g_num = pv;
         g_den = pa;
      end else if (pv >= pa && pv <= pc) begin
         ramp_in[1].force_en  = 1'b1;
         ramp_in[1].force_val = th565_pkg::CAP_COLD;
      end else if (pv <= pc) begin
         ramp_in[1].force_en  = 1'b1;
      end
      if (!ramp_in[1].force_en && g_num <= 0) ramp_in[1].force_en = 1'b1;
      ramp_in[1].num = g_num[th565_pkg::NUM_W-1:0];
      ramp_in[1].den = g_den[th565_pkg::DEN_W-1:0];
      ramp_in[1].hot = 1'b0;

      ramp_in[2].force_en  = 1'b0;
      ramp_in[2].force_val = 8'd0;
      ramp_in[2].hot       = 1'b0;
      if (pv <= pb) begin
         b_num = pb - pv;
         b_den = pb - pa;
         if (b_num <= 0) ramp_in[2].force_en = 1'b1;
      end else if (pv <= pd) begin
         b_num = pv - pd;
         b_den = ph - pd;
         ramp_in[2].force_en = 1'b1;
      end else begin
         b_num = pv - pd;
         b_den = ph - pd;
         ramp_in[2].hot = 1'b1;
      end
      ramp_in[2].num = b_num[th565_pkg::NUM_W-1:0];
      ramp_in[2].den = b_den[th565_pkg::DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (adv) s3_vld_ff <= s2_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_deg_ff  <= s2_deg_ff;
         s3_ramp_ff <= ramp_in;
      end
   end

   // stage 4: apply gain (255 or 240) by shift and subtract
   th565_pkg::div_type s4_ff [NCH];
   logic s4_vld_ff, s4_deg_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (adv) s4_vld_ff <= s3_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_deg_ff <= s3_deg_ff;
         for (int ch = 0; ch < NCH; ch++) begin
            s4_ff[ch].done <= s3_ramp_ff[ch].force_en;
            s4_ff[ch].quo  <= s3_ramp_ff[ch].force_val;
            s4_ff[ch].den  <= s3_ramp_ff[ch].den;
            s4_ff[ch].hot  <= s3_ramp_ff[ch].hot;
            if (s3_ramp_ff[ch].hot)
               s4_ff[ch].rem <= (th565_pkg::REM_W'(s3_ramp_ff[ch].num) << 8)
                              - (th565_pkg::REM_W'(s3_ramp_ff[ch].num) << 4);
            else
               s4_ff[ch].rem <= (th565_pkg::REM_W'(s3_ramp_ff[ch].num) << 8)
                              - th565_pkg::REM_W'(s3_ramp_ff[ch].num);
         end
      end
   end

   // divider: stage 0 saturates, stages 1..8 resolve one quotient bit each
   th565_pkg::div_type dv_ff [NDV][NCH];
   logic [NDV-1:0] dv_vld_ff, dv_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff <= '0;
      else if (adv) dv_vld_ff <= {dv_vld_ff[NDV-2:0], s4_vld_ff};
   end
   always_ff @(posedge clock) begin
      if (adv) dv_deg_ff <= {dv_deg_ff[NDV-2:0], s4_deg_ff};
   end

   for (genvar ch = 0; ch < NCH; ch++) begin : g_sat
      th565_pkg::div_type sat_in;
      always_comb begin
         sat_in = s4_ff[ch];
         if (!sat_in.done) begin
            sat_in.quo = '0;
            if (sat_in.rem >= (th565_pkg::REM_W'(sat_in.den) << th565_pkg::QUO_W)) begin
               sat_in.done = 1'b1;
               sat_in.quo  = sat_in.hot ? th565_pkg::CAP_HOT : th565_pkg::CAP_COLD;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) dv_ff[0][ch] <= sat_in;
      end
   end

   for (genvar st = 1; st < NDV; st++) begin : g_div
      for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
         localparam int BIT = th565_pkg::QUO_W - st;
         th565_pkg::div_type step_in;
         logic [th565_pkg::REM_W-1:0] trial;
         always_comb begin
            step_in = dv_ff[st-1][ch];
            trial   = th565_pkg::REM_W'(step_in.den) << BIT;
            if (!step_in.done && step_in.rem >= trial) begin
               step_in.rem      = step_in.rem - trial;
               step_in.quo[BIT] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) dv_ff[st][ch] <= step_in;
         end
      end
   end

   // output stage: cap the hot ramp, pack 5-6-5, force black on a degenerate scale
   logic [7:0] lvl [NCH];
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         lvl[ch] = dv_ff[NDV-1][ch].quo;
         if (dv_ff[NDV-1][ch].hot && lvl[ch] > th565_pkg::CAP_HOT)
            lvl[ch] = th565_pkg::CAP_HOT;
         if (dv_deg_ff[NDV-1]) lvl[ch] = 8'd0;
      end
   end

   logic rsp_vld_ff;
   assign rsp_valid = rsp_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (adv) rsp_vld_ff <= dv_vld_ff[NDV-1];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_level   <= lvl[0];
         rsp_green_level <= lvl[1];
         rsp_blue_level  <= lvl[2];
         rsp_color565    <= {lvl[0][7:3], lvl[1][7:2], lvl[2][7:3]};
         rsp_degenerate  <= dv_deg_ff[NDV-1];
      end
   end

   a_deg_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_color565 == 16'd0)
      else $error("degenerate pixel not black");

   a_cold_no_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blue_level > th565_pkg::CAP_HOT |-> rsp_red_level == 8'd0)
      else $error("cold blue saturation with red present");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("pipeline held without a waiting item");

endmodule
`default_nettype wire
